/* hw/rtl/bitmap_page_allocator_macros.svh */
// Assertion macros for the bitmap page allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hw/rtl/bpa_pkg.sv */
// Types and constants of the bitmap page allocator.
package bpa_pkg;

	localparam int PAGE_W     = 16;
	localparam int COUNT_W    = 17;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;
	localparam int PAGE_SPACE = 65536;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_FREE    = 2'd1,
		ACT_USABLE  = 2'd2,
		ACT_RESERVE = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_NO_CHANGE = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ADDR,
		S_CHECK,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [PAGE_W-1:0]   page;
		logic [COUNT_W-1:0]  count;
	} result_t;

endpackage

/* hw/rtl/bpa_channels.sv */
// Request and response channel interfaces of the bitmap page allocator.
interface bpa_req_if;
	logic                        valid;
	logic                        ready;
	logic [bpa_pkg::ACT_W-1:0]   action;
	logic [bpa_pkg::PAGE_W-1:0]  page_number;

	modport source(output valid, action, page_number, input ready);
	modport sink(input valid, action, page_number, output ready);
endinterface

interface bpa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bpa_pkg::STAT_W-1:0]   status;
	logic [bpa_pkg::PAGE_W-1:0]   result_page;
	logic [bpa_pkg::COUNT_W-1:0]  free_count;

	modport source(output valid, status, result_page, free_count, input ready);
	modport sink(input valid, status, result_page, free_count, output ready);
endinterface

/* hw/rtl/bpa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/bpa_find.sv */
// First-free-bit search over one map word, limited to the pages below the limit.
module bpa_find #(
	parameter int WORD_BITS = 64,
	localparam int BW = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0]          used,
	input  logic [bpa_pkg::COUNT_W-1:0]   span,
	output logic                          found,
	output logic [BW-1:0]                 bit_idx
);

	localparam int CW = bpa_pkg::COUNT_W;

	logic [WORD_BITS-1:0] avail;

	// Drop bits at or above the limit in a partial last word.
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			avail[i] = ~used[i] & (CW'(i) < span);
		end
	end

	always_comb begin
		found   = |avail;
		bit_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				bit_idx = BW'(i);
			end
		end
	end

endmodule

/* hw/rtl/bitmap_page_allocator.sv */
// Bitmap page frame allocator: top level with control sequencer and map RAM.
//
// One used bit per page, held in a RAM of MAP_WORD_BITS-wide words
// (ceil(min(MAX_PAGES, 65536) / MAP_WORD_BITS) entries). After reset the
// block sweeps that RAM once, one word a cycle, to mark every page used;
// requests are held off for those cycles while configuration writes are
// taken. Allocate reads the map one word per cycle from page 0 up and stops
// at the first word with a free page below the limit (or after every word
// below the limit when none is free). Free, mark usable and mark reserved
// step through word index, RAM read, bit update and write back, response.
// An out-of-range page, or allocate with a limit of zero, goes straight from
// the request to the response. A finished response sits in an output
// register, so the next request is taken while it waits.
`include "bitmap_page_allocator_macros.svh"

module bitmap_page_allocator #(
	parameter int MAX_PAGES     = 65536,
	parameter int MAP_WORD_BITS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bpa_pkg::COUNT_W-1:0]  cfg_wdata,
	bpa_req_if.sink                      req,
	bpa_rsp_if.source                    rsp
);

	localparam int CW       = bpa_pkg::COUNT_W;
	localparam int PW       = bpa_pkg::PAGE_W;
	localparam int W        = MAP_WORD_BITS;
	localparam int CAP      = (MAX_PAGES < bpa_pkg::PAGE_SPACE) ? MAX_PAGES
	                                                            : bpa_pkg::PAGE_SPACE;
	localparam int DEPTH    = (CAP + W - 1) / W;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW       = $clog2(W);
	// page / W as a multiply by a rounded-up reciprocal; exact for 16-bit pages
	localparam int RECIP_SH = 24;
	localparam int RECIP    = ((1 << RECIP_SH) + W - 1) / W;
	localparam int RECIP_W  = $clog2(RECIP + 1);
	localparam int PROD_W   = PW + RECIP_W;

	bpa_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    lim_q;
	logic [CW-1:0]    free_q;
	logic [AW-1:0]    clr_idx_q;
	logic [AW-1:0]    rd_idx_q;
	logic [CW-1:0]    rd_base_q;
	logic             chk_valid_q;
	logic             out_valid_q;

	bpa_pkg::action_t act_q;
	logic [PW-1:0]    page_q;
	logic [AW-1:0]    q_q;
	logic [BW-1:0]    bit_q;
	logic [CW-1:0]    chk_base_q;
	logic [AW-1:0]    chk_idx_q;
	bpa_pkg::result_t pend_q;
	bpa_pkg::result_t out_q;

	bpa_pkg::action_t req_act;
	logic             accept;
	logic             out_free;
	logic             issue;
	logic [PROD_W-1:0] prod;
	logic [31:0]      q_times_w;
	logic [CW-1:0]    span;
	logic             last_word;
	logic             found;
	logic [BW-1:0]    fbit;
	logic [W-1:0]     bit_mask;
	logic [W-1:0]     fbit_mask;
	logic             bit_used;
	logic [CW-1:0]    free_dec;
	logic [CW-1:0]    free_inc;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [W-1:0]     ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [W-1:0]     ram_rdata;

	logic             res_load;
	bpa_pkg::result_t res_d;
	logic [CW-1:0]    free_d;

	bpa_ram #(
		.WIDTH(W),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bpa_find #(
		.WORD_BITS(W)
	) u_find (
		.used   (ram_rdata),
		.span   (span),
		.found  (found),
		.bit_idx(fbit)
	);

	assign req_act   = bpa_pkg::action_t'(req.action);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign issue     = rd_base_q < lim_q;
	assign prod      = PROD_W'(req.page_number) * PROD_W'(RECIP);
	assign q_times_w = 32'(q_q) * 32'(W);
	assign span      = lim_q - chk_base_q;
	assign last_word = span <= CW'(W);
	assign bit_mask  = W'(1) << bit_q;
	assign fbit_mask = W'(1) << fbit;
	assign bit_used  = ram_rdata[bit_q];
	assign free_dec  = (free_q != '0) ? free_q - CW'(1) : free_q;
	assign free_inc  = free_q + CW'(1);

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.result_page = out_q.page;
	assign rsp.free_count  = out_q.count;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				if (clr_idx_q == AW'(DEPTH - 1)) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_IDLE: begin
				if (req.valid) begin
					if (req_act == bpa_pkg::ACT_ALLOC) begin
						state_d = (lim_q == '0) ? bpa_pkg::S_RESP : bpa_pkg::S_SCAN;
					end else if (CW'(req.page_number) >= lim_q) begin
						state_d = bpa_pkg::S_RESP;
					end else begin
						state_d = bpa_pkg::S_ADDR;
					end
				end
			end
			bpa_pkg::S_SCAN: begin
				if (chk_valid_q && (found || last_word)) begin
					state_d = bpa_pkg::S_RESP;
				end
			end
			bpa_pkg::S_ADDR:  state_d = bpa_pkg::S_CHECK;
			bpa_pkg::S_CHECK: state_d = bpa_pkg::S_RESP;
			bpa_pkg::S_RESP: begin
				if (out_free) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			default: state_d = bpa_pkg::S_CLEAR;
		endcase
	end

	// Outputs: RAM port controls, ready and the result of the current step.
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = q_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = q_q;
		res_load  = 1'b0;
		res_d     = '{status: bpa_pkg::ST_DONE, page: page_q, count: free_q};
		free_d    = free_q;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '1;
			end
			bpa_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					res_load = 1'b1;
					if (req_act == bpa_pkg::ACT_ALLOC) begin
						res_d = '{status: bpa_pkg::ST_NO_FREE, page: '0, count: free_q};
					end else begin
						res_d = '{status: bpa_pkg::ST_RANGE, page: '0, count: free_q};
					end
				end
			end
			bpa_pkg::S_SCAN: begin
				ram_re    = issue;
				ram_raddr = rd_idx_q;
				if (chk_valid_q) begin
					if (found) begin
						// claim the lowest free page of this word
						ram_we    = 1'b1;
						ram_waddr = chk_idx_q;
						ram_wdata = ram_rdata | fbit_mask;
						free_d    = free_dec;
						res_load  = 1'b1;
						res_d     = '{status: bpa_pkg::ST_DONE,
						              page: PW'(chk_base_q + CW'(fbit)),
						              count: free_dec};
					end else if (last_word) begin
						res_load = 1'b1;
						res_d    = '{status: bpa_pkg::ST_NO_FREE, page: '0, count: free_q};
					end
				end
			end
			bpa_pkg::S_ADDR: begin
				ram_re = 1'b1;
			end
			bpa_pkg::S_CHECK: begin
				res_load = 1'b1;
				if (act_q == bpa_pkg::ACT_RESERVE) begin
					if (bit_used) begin
						res_d.status = bpa_pkg::ST_NO_CHANGE;
					end else begin
						ram_we      = 1'b1;
						ram_wdata   = ram_rdata | bit_mask;
						free_d      = free_dec;
						res_d.count = free_dec;
					end
				end else begin
					if (!bit_used) begin
						res_d.status = bpa_pkg::ST_NO_CHANGE;
					end else begin
						ram_we      = 1'b1;
						ram_wdata   = ram_rdata & ~bit_mask;
						free_d      = free_inc;
						res_d.count = free_inc;
					end
				end
			end
			bpa_pkg::S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpa_pkg::S_CLEAR;
			lim_q       <= '0;
			free_q      <= '0;
			clr_idx_q   <= '0;
			rd_idx_q    <= '0;
			rd_base_q   <= '0;
			chk_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			if (cfg_we) begin
				lim_q <= (cfg_wdata > CW'(CAP)) ? CW'(CAP) : cfg_wdata;
			end
			if (state_q == bpa_pkg::S_CLEAR) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (accept) begin
				rd_idx_q    <= '0;
				rd_base_q   <= '0;
				chk_valid_q <= 1'b0;
			end else if (state_q == bpa_pkg::S_SCAN) begin
				chk_valid_q <= issue;
				if (issue) begin
					rd_idx_q  <= rd_idx_q + AW'(1);
					rd_base_q <= rd_base_q + CW'(W);
				end
			end
			if (state_q == bpa_pkg::S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= req_act;
			page_q <= req.page_number;
			q_q    <= prod[RECIP_SH +: AW];
		end
		if (state_q == bpa_pkg::S_ADDR) begin
			bit_q <= BW'(page_q - q_times_w[PW-1:0]);
		end
		if (state_q == bpa_pkg::S_SCAN) begin
			chk_base_q <= rd_base_q;
			chk_idx_q  <= rd_idx_q;
		end
		if (res_load) begin
			pend_q <= res_d;
		end
		if (state_q == bpa_pkg::S_RESP && out_free) begin
			out_q <= pend_q;
		end
	end

	`BPA_ASSERT_NEXT(a_one_item, clk, arst_n, req.valid && req.ready, !req.ready, "request taken while busy")
	`BPA_ASSERT_NOW(a_free_cap, clk, arst_n, 1'b1, free_q <= CW'(CAP), "free count above page capacity")
	`BPA_ASSERT_NOW(a_fail_page, clk, arst_n, rsp.valid && (rsp.status == bpa_pkg::ST_NO_FREE || rsp.status == bpa_pkg::ST_RANGE), rsp.result_page == '0, "failed beat carries a page")
	`BPA_ASSERT_NOW(a_clear_quiet, clk, arst_n, state_q == bpa_pkg::S_CLEAR, !rsp.valid && !req.ready, "channel active during map clear")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the bitmap page allocator: directed table, then random limit phases.
module tb_top;
	import bpa_pkg::*;

	localparam int HANG_LIMIT = 10_000_000;
	localparam int PHASES     = 11;
	localparam int TAIL_WAIT  = 40;

	typedef struct packed {
		bit                  set_cfg;
		logic [COUNT_W-1:0]  cfg;
		action_t             act;
		logic [PAGE_W-1:0]   page;
		bit                  known;
		status_t             st;
		logic [PAGE_W-1:0]   rpage;
		logic [COUNT_W-1:0]  cnt;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [COUNT_W-1:0]  cfg_wdata = '0;

	bpa_req_if req_if ();
	bpa_rsp_if rsp_if ();

	bitmap_page_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the allocator state
	bit                  page_used [PAGE_SPACE];
	logic [COUNT_W-1:0]  shadow_free;
	int unsigned         page_limit;

	result_t             pending_results [$];
	int                  idle_pct;
	int                  mismatches;
	int                  requests_sent;
	int                  limit_writes;
	int                  n_done, n_no_free, n_no_change, n_range;

	// Directed rows: limit writes, extremes, every action and every status
	script_row_t directed_rows [24] = '{
		'{1'b1, 17'd0,     ACT_ALLOC,   16'd0,     1'b1, ST_NO_FREE,   16'd0,     17'd0},
		'{1'b0, 17'd0,     ACT_RESERVE, 16'd65535, 1'b1, ST_RANGE,     16'd0,     17'd0},
		'{1'b1, 17'd65536, ACT_USABLE,  16'd65535, 1'b1, ST_DONE,      16'd65535, 17'd1},
		'{1'b0, 17'd0,     ACT_USABLE,  16'd65535, 1'b1, ST_NO_CHANGE, 16'd65535, 17'd1},
		'{1'b0, 17'd0,     ACT_FREE,    16'd0,     1'b1, ST_DONE,      16'd0,     17'd2},
		'{1'b0, 17'd0,     ACT_ALLOC,   16'd0,     1'b1, ST_DONE,      16'd0,     17'd1},
		'{1'b0, 17'd0,     ACT_ALLOC,   16'hFFFF,  1'b1, ST_DONE,      16'd65535, 17'd0},
		'{1'b0, 17'd0,     ACT_ALLOC,   16'd7,     1'b1, ST_NO_FREE,   16'd0,     17'd0},
		'{1'b0, 17'd0,     ACT_RESERVE, 16'd100,   1'b1, ST_NO_CHANGE, 16'd100,   17'd0},
		'{1'b0, 17'd0,     ACT_FREE,    16'h5555,  1'b1, ST_DONE,      16'h5555,  17'd1},
		'{1'b0, 17'd0,     ACT_USABLE,  16'hAAAA,  1'b1, ST_DONE,      16'hAAAA,  17'd2},
		'{1'b0, 17'd0,     ACT_RESERVE, 16'h5555,  1'b0, ST_DONE,      16'd0,     17'd0},
		'{1'b1, 17'd64,    ACT_USABLE,  16'd63,    1'b1, ST_DONE,      16'd63,    17'd2},
		'{1'b0, 17'd0,     ACT_USABLE,  16'd64,    1'b1, ST_RANGE,     16'd0,     17'd2},
		'{1'b0, 17'd0,     ACT_ALLOC,   16'd0,     1'b1, ST_DONE,      16'd63,    17'd1},
		'{1'b0, 17'd0,     ACT_ALLOC,   16'd0,     1'b1, ST_NO_FREE,   16'd0,     17'd1},
		'{1'b1, 17'd65,    ACT_USABLE,  16'd64,    1'b1, ST_DONE,      16'd64,    17'd2},
		'{1'b0, 17'd0,     ACT_FREE,    16'd64,    1'b0, ST_DONE,      16'd0,     17'd0},
		'{1'b0, 17'd0,     ACT_ALLOC,   16'd0,     1'b0, ST_DONE,      16'd0,     17'd0},
		'{1'b1, 17'd1,     ACT_FREE,    16'd0,     1'b1, ST_DONE,      16'd0,     17'd2},
		'{1'b0, 17'd0,     ACT_FREE,    16'd1,     1'b1, ST_RANGE,     16'd0,     17'd2},
		'{1'b0, 17'd0,     ACT_ALLOC,   16'd0,     1'b1, ST_DONE,      16'd0,     17'd1},
		'{1'b1, 17'd65536, ACT_ALLOC,   16'd0,     1'b1, ST_DONE,      16'hAAAA,  17'd0},
		'{1'b0, 17'd0,     ACT_RESERVE, 16'hAAAA,  1'b1, ST_NO_CHANGE, 16'hAAAA,  17'd0}
	};

	// Lowered limits after wide ones leave free pages stranded above the limit
	logic [COUNT_W-1:0] phase_limit [PHASES] = '{
		17'd1, 17'd64, 17'd65, 17'd200, 17'd1024, 17'd0,
		17'd63, 17'd2048, 17'd65536, 17'd130, 17'd512
	};
	int phase_items [PHASES] = '{60, 130, 130, 130, 130, 20, 100, 130, 60, 130, 130};

	function automatic bit skip_cycle();
		return $urandom_range(99) < idle_pct;
	endfunction

	function automatic result_t next_page_result(input action_t act, input logic [PAGE_W-1:0] pg);
		result_t      r;
		int unsigned  i;
		bit           found;
		r.status = ST_DONE;
		r.page = '0;
		found = 1'b0;
		if (act == ACT_ALLOC) begin
			for (i = 0; i < page_limit && !found; i++) begin
				if (!page_used[i]) begin
					found = 1'b1;
					r.page = 16'(i);
				end
			end
			if (found) begin
				page_used[r.page] = 1'b1;
				if (shadow_free != 0)
					shadow_free = shadow_free - 1'b1;
			end else begin
				r.status = ST_NO_FREE;
			end
		end else if (pg >= page_limit) begin
			r.status = ST_RANGE;
		end else if (act == ACT_RESERVE) begin
			r.page = pg;
			if (page_used[pg]) begin
				r.status = ST_NO_CHANGE;
			end else begin
				page_used[pg] = 1'b1;
				if (shadow_free != 0)
					shadow_free = shadow_free - 1'b1;
			end
		end else begin
			// free and mark usable act alike
			r.page = pg;
			if (!page_used[pg]) begin
				r.status = ST_NO_CHANGE;
			end else begin
				page_used[pg] = 1'b0;
				shadow_free = shadow_free + 1'b1;
			end
		end
		r.count = shadow_free;
		return r;
	endfunction

	// Present one request beat; record its expected response on acceptance
	task automatic put_request(input action_t act, input logic [PAGE_W-1:0] pg,
			input bit use_typed, input result_t typed);
		result_t predicted;
		@(negedge clk);
		while (skip_cycle()) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.action = act;
		req_if.page_number = pg;
		do @(posedge clk); while (!req_if.ready);
		predicted = next_page_result(act, pg);
		pending_results.push_back(use_typed ? typed : predicted);
		requests_sent++;
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_page_limit(input logic [COUNT_W-1:0] pages);
		hold_until_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = pages;
		@(negedge clk);
		cfg_we = 1'b0;
		page_limit = (pages > PAGE_SPACE) ? PAGE_SPACE : pages;
		limit_writes++;
	endtask

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready = !skip_cycle();
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			case (status_t'(rsp_if.status))
				ST_DONE:      n_done++;
				ST_NO_FREE:   n_no_free++;
				ST_NO_CHANGE: n_no_change++;
				default:      n_range++;
			endcase
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: response beat with nothing expected, status %0d page %0d count %0d",
					$time, rsp_if.status, rsp_if.result_page, rsp_if.free_count);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d, got %0d", $time, want.status, rsp_if.status);
				end
				if (rsp_if.result_page !== want.page) begin
					mismatches++;
					$display("%0t: result_page expected %0d, got %0d",
						$time, want.page, rsp_if.result_page);
				end
				if (rsp_if.free_count !== want.count) begin
					mismatches++;
					$display("%0t: free_count expected %0d, got %0d",
						$time, want.count, rsp_if.free_count);
				end
			end
		end
	end

	initial begin
		#HANG_LIMIT;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [PAGE_W-1:0]  pg;
		action_t            act;
		int unsigned        lim, pick, alloc_w;
		int                 p, n;
		req_if.valid = 1'b0;
		req_if.action = ACT_ALLOC;
		req_if.page_number = '0;
		foreach (page_used[i])
			page_used[i] = 1'b1;
		shadow_free = '0;
		page_limit = 0;
		idle_pct = 8;
		mismatches = 0;
		requests_sent = 0;
		limit_writes = 0;
		n_done = 0;
		n_no_free = 0;
		n_no_change = 0;
		n_range = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].set_cfg)
				set_page_limit(directed_rows[k].cfg);
			put_request(directed_rows[k].act, directed_rows[k].page, directed_rows[k].known,
				'{directed_rows[k].st, directed_rows[k].rpage, directed_rows[k].cnt});
		end

		for (p = 0; p < PHASES; p++) begin
			set_page_limit(phase_limit[p]);
			lim = page_limit;
			// one whole phase runs with no idling on either side
			idle_pct = (p == 3) ? 0 : 8;
			alloc_w = $urandom_range(55, 20);
			for (n = 0; n < phase_items[p]; n++) begin
				if (n == phase_items[p] / 2)
					hold_until_drained();
				pick = $urandom_range(99);
				pg = 16'($urandom);
				if (pick < alloc_w) begin
					act = ACT_ALLOC;
				end else begin
					act = action_t'(2'($urandom_range(3, 1)));
					if (pick < 94 && lim != 0)
						pg = 16'($urandom_range(lim - 1, 0));
					else if (lim < PAGE_SPACE)
						pg = 16'($urandom_range(PAGE_SPACE - 1, lim));
				end
				put_request(act, pg, 1'b0, '0);
			end
		end

		hold_until_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		$display("Ran %0d requests across %0d page limit writes.", requests_sent, limit_writes);
		$display("Responses: %0d done, %0d no free page, %0d unchanged, %0d out of range.",
			n_done, n_no_free, n_no_change, n_range);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_channels.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_find.sv
hw/rtl/bitmap_page_allocator.sv
test/tb_top.sv
